// ===== hdl/tiny_core_instruction_executor_assert.svh =====
// Assertion macros for the tiny core execute unit.
`ifndef TINY_CORE_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define TINY_CORE_INSTRUCTION_EXECUTOR_ASSERT_SVH

`ifndef SYNTHESIS

`define TCE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`define TCE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TCE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`define TCE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/tce_pkg.sv =====
// Types and constants shared by the tiny core execute unit.
`default_nettype none

package tce_pkg;

    localparam int NUM_REGS = 8;
    localparam int PC_BITS  = 16;
    localparam int REG_AW   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    typedef enum logic [1:0] {
        CMD_EXEC      = 2'd0,
        CMD_LOAD_RET  = 2'd1,
        CMD_WRITE_REG = 2'd2,
        CMD_NONE      = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        OP_LOAD  = 3'd0,
        OP_STORE = 3'd1,
        OP_FMUL  = 3'd2,
        OP_FADD  = 3'd3,
        OP_INC   = 3'd4,
        OP_DEC   = 3'd5,
        OP_JNZ   = 3'd6,
        OP_NOP   = 3'd7
    } t_opcode;

    typedef enum logic [1:0] {
        MEM_NONE  = 2'd0,
        MEM_READ  = 2'd1,
        MEM_WRITE = 2'd2
    } t_mem_op;

    typedef struct packed {
        t_cmd        command;
        t_opcode     opcode;
        logic [2:0]  dest_reg;
        logic        dest_is_mem;
        logic [2:0]  src1_reg;
        logic        src1_is_mem;
        logic [2:0]  src2_reg;
        logic [2:0]  cond_reg;
        logic [15:0] jump_target;
        logic [63:0] value;
    } t_cmd_beat;

    typedef struct packed {
        logic [15:0] next_pc;
        t_mem_op     mem_op;
        logic [63:0] mem_addr;
        logic [63:0] mem_wdata;
        logic        store_error;
    } t_res_beat;

endpackage

`default_nettype wire

// ===== hdl/tce_if.sv =====
// Command and result channel interfaces of the tiny core execute unit.
`default_nettype none

interface tce_cmd_if import tce_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cmd_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tce_res_if import tce_pkg::*; ();
    logic      valid;
    logic      ready;
    t_res_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/tiny_core_instruction_executor.sv =====
// Tiny core execute unit: register file, program counter and result register.
// Each command beat is executed in the cycle it is accepted and its single result
// beat appears in the output register the next cycle; a new beat is accepted every
// cycle while the output register is empty or being drained. FMUL registers its
// low 32x32 product and summed cross products and adds them into the destination
// register in the following cycle, during which no command is accepted. All others
// finish on acceptance. Eight 64-bit registers and the PC reset to zero.
`default_nettype none
`include "tiny_core_instruction_executor_assert.svh"

module tiny_core_instruction_executor import tce_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    tce_cmd_if.sink     i_cmd,
    tce_res_if.source   o_res
);

    logic [63:0]        r_regs [NUM_REGS];
    logic [PC_BITS-1:0] r_pc;
    logic [2:0]         r_pend;
    logic               r_out_valid;
    t_res_beat          r_out;
    logic               r_mul_busy;
    logic [63:0]        r_pp_ll;
    logic [31:0]        r_pp_x;
    logic [2:0]         r_mul_dest;

    logic               w_accept;
    t_cmd_beat          w_in;
    logic [2:0]         w_sel_b;
    logic [63:0]        w_rd_a;
    logic [63:0]        w_rd_b;
    logic [63:0]        w_pp_ll;
    logic [31:0]        w_pp_x;
    logic [PC_BITS-1:0] n_pc;
    logic [2:0]         n_pend;
    t_res_beat          n_out;
    logic               w_wr_en;
    logic [2:0]         w_wr_idx;
    logic [63:0]        w_wr_val;
    logic               w_mul_start;

    function automatic logic idx_ok(input logic [2:0] idx);
        return 32'(idx) < NUM_REGS;
    endfunction

    function automatic logic [REG_AW-1:0] idx_addr(input logic [2:0] idx);
        return REG_AW'(idx);
    endfunction

    assign w_in        = i_cmd.data;
    assign i_cmd.ready = (!r_out_valid || o_res.ready) && !r_mul_busy;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    always_comb begin
        unique case (w_in.opcode)
            OP_STORE, OP_INC, OP_DEC: w_sel_b = w_in.dest_reg;
            OP_JNZ:                   w_sel_b = w_in.cond_reg;
            default:                  w_sel_b = w_in.src2_reg;
        endcase
    end

    assign w_rd_a = idx_ok(w_in.src1_reg) ? r_regs[idx_addr(w_in.src1_reg)] : 64'd0;
    assign w_rd_b = idx_ok(w_sel_b) ? r_regs[idx_addr(w_sel_b)] : 64'd0;

    assign w_pp_ll = 64'(w_rd_a[31:0]) * 64'(w_rd_b[31:0]);
    assign w_pp_x  = w_rd_a[31:0] * w_rd_b[63:32] + w_rd_a[63:32] * w_rd_b[31:0];

    always_comb begin
        n_pc              = r_pc;
        n_pend            = r_pend;
        w_wr_en           = 1'b0;
        w_wr_idx          = w_in.dest_reg;
        w_wr_val          = w_rd_a;
        w_mul_start       = 1'b0;
        n_out.mem_op      = MEM_NONE;
        n_out.mem_addr    = 64'd0;
        n_out.mem_wdata   = 64'd0;
        n_out.store_error = 1'b0;
        unique case (w_in.command)
            CMD_EXEC: begin
                n_pc = r_pc + PC_BITS'(1);
                unique case (w_in.opcode)
                    OP_LOAD: begin
                        if (w_in.src1_is_mem) begin
                            n_out.mem_op   = MEM_READ;
                            n_out.mem_addr = w_rd_a;
                            n_pend         = w_in.dest_reg;
                        end else begin
                            w_wr_en = 1'b1;
                        end
                    end
                    OP_STORE: begin
                        if (w_in.dest_is_mem) begin
                            n_out.mem_op    = MEM_WRITE;
                            n_out.mem_addr  = w_rd_b;
                            n_out.mem_wdata = w_rd_a;
                        end else begin
                            n_out.store_error = 1'b1;
                        end
                    end
                    OP_FMUL: w_mul_start = 1'b1;
                    OP_FADD: begin
                        w_wr_en  = 1'b1;
                        w_wr_val = w_rd_a + w_rd_b;
                    end
                    OP_INC: begin
                        w_wr_en  = 1'b1;
                        w_wr_val = w_rd_b + 64'd1;
                    end
                    OP_DEC: begin
                        w_wr_en  = 1'b1;
                        w_wr_val = w_rd_b - 64'd1;
                    end
                    OP_JNZ: begin
                        if (w_rd_b != 64'd0) begin
                            n_pc = PC_BITS'(w_in.jump_target);
                        end
                    end
                    OP_NOP: ;
                endcase
            end
            CMD_LOAD_RET: begin
                w_wr_en  = 1'b1;
                w_wr_idx = r_pend;
                w_wr_val = w_in.value;
            end
            CMD_WRITE_REG: begin
                w_wr_en  = 1'b1;
                w_wr_val = w_in.value;
            end
            CMD_NONE: ;
        endcase
        n_out.next_pc = 16'(n_pc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= 64'd0;
            end
            r_pc        <= '0;
            r_pend      <= 3'd0;
            r_out_valid <= 1'b0;
            r_mul_busy  <= 1'b0;
        end else begin
            if (r_mul_busy && idx_ok(r_mul_dest)) begin
                r_regs[idx_addr(r_mul_dest)] <= r_pp_ll + {r_pp_x, 32'd0};
            end
            r_mul_busy <= w_accept && w_mul_start;
            if (w_accept) begin
                if (w_wr_en && idx_ok(w_wr_idx)) begin
                    r_regs[idx_addr(w_wr_idx)] <= w_wr_val;
                end
                r_pc        <= n_pc;
                r_pend      <= n_pend;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out      <= n_out;
            r_pp_ll    <= w_pp_ll;
            r_pp_x     <= w_pp_x;
            r_mul_dest <= w_in.dest_reg;
        end
    end

    `TCE_ASSERT_IMP(a_mul_stalls_cmd, i_clk, i_rst_n, r_mul_busy, !i_cmd.ready, "ready in write-back")
    `TCE_ASSERT_NXT(a_mul_starts, i_clk, i_rst_n, w_accept && w_mul_start, r_mul_busy, "no write-back")
    `TCE_ASSERT_NXT(a_mul_one_cycle, i_clk, i_rst_n, r_mul_busy, !r_mul_busy, "long write-back")
    `TCE_ASSERT_NXT(a_accept_gives_result, i_clk, i_rst_n, w_accept, r_out_valid, "no result beat")

endmodule

`default_nettype wire
